// ===== sv/ssc_pkg.sv =====
// Shared constants, register codes and types of the solver stop-criterion monitor.
package ssc_pkg;

  // Word widths of the value channels and the step counter
  localparam int VALUE_WIDTH = 48;
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_W       = COUNT_WIDTH + 1;

  // Criteria
  localparam int NUM_CRIT = 13;
  localparam int CRIT_W   = 4;
  localparam logic [CRIT_W-1:0] CRIT_NONE = CRIT_W'(NUM_CRIT);

  // Base index of each channel's six tests in the hit vector
  localparam int LOAD_BASE  = 1;
  localparam int STATE_BASE = 7;
  localparam int CHAN_TESTS = 6;

  // Step counts from which the history tests may look back
  localparam logic [CNT_W-1:0] MIN_STEPS_SIGN = CNT_W'(2);
  localparam logic [CNT_W-1:0] MIN_STEPS_EXT  = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_CAP        = {1'b1, {COUNT_WIDTH{1'b0}}};

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + CRIT_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_LIMIT       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOAD_LOW_LIMIT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOAD_HIGH_LIMIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STATE_LOW_LIMIT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STATE_HIGH_LIMIT = 3'd5;

  // Extreme words standing in for minus and plus infinity
  localparam logic [VALUE_WIDTH-1:0] VALUE_MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] VALUE_MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [NUM_CRIT-1:0]           enable_mask;
    logic [COUNT_WIDTH-1:0]        step_limit;
    logic signed [VALUE_WIDTH-1:0] load_low_limit;
    logic signed [VALUE_WIDTH-1:0] load_high_limit;
    logic signed [VALUE_WIDTH-1:0] state_low_limit;
    logic signed [VALUE_WIDTH-1:0] state_high_limit;
  } cfg_t;

  // Step-count gates shared by both channels
  typedef struct packed {
    logic ge2;
    logic ge3;
  } cnt_gate_t;

endpackage

// ===== sv/solver_stop_criterion_monitor.sv =====
// Top level of the solver stop-criterion monitor: stream stages, step counter, priority pick.
//
// One input item per finished solver step enters on the in_ channel; tdata holds the
// load value and the watched state value, both signed Q24.24. For every item exactly
// one result leaves on the out_ channel with the stop flag and the index of the first
// criterion that fired (13 when none did).
// An accepted item passes first into the input register; once the result register is
// free, the comparisons and the priority pick are loaded into the result register.
// Throughput is one item per cycle while out_tready is high; the input register and the
// result register each hold an item, so the block keeps accepting while a result waits.
// When the receiver stalls, the result is held, the input register fills, and
// in_tready drops only once both are occupied.
// The cfg_ port is an APB-style port with 64-bit data; register i lies at byte
// address 8*i. Write it only while the block is empty.
// Synchronous reset clears the step count, both histories and the stages, and loads
// the registers with their reset values: only criterion zero enabled, the largest
// step limit and the most negative and most positive value limits.
module solver_stop_criterion_monitor (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata: [47:0] load_value, [95:48] state_value
  input  logic [ssc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: [0] stop_flag, [4:1] criterion, [7:5] zero
  output logic [ssc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ssc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import ssc_pkg::*;

  cfg_t                          cfg;
  logic                          in_vld_r;
  logic signed [VALUE_WIDTH-1:0] in_load_r;
  logic signed [VALUE_WIDTH-1:0] in_state_r;
  logic                          out_vld_r;
  logic                          out_stop_r;
  logic [CRIT_W-1:0]             out_crit_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          out_free;
  logic                          advance;
  cnt_gate_t                     gate;
  logic [NUM_CRIT-1:0]           hits;
  logic [NUM_CRIT-1:0]           enabled;
  logic [NUM_CRIT-1:0]           fired;
  logic [CRIT_W-1:0]             crit;

  ssc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Handshake: the stage moves on whenever the result register is free
  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_load_r  <= in_tdata[VALUE_WIDTH-1:0];
      in_state_r <= in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    end
  end

  // Saturating step count, including the item under test
  assign count_nxt = (count_r < CNT_CAP) ? count_r + CNT_W'(1) : count_r;
  assign gate.ge2  = count_nxt >= MIN_STEPS_SIGN;
  assign gate.ge3  = count_nxt >= MIN_STEPS_EXT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

  assign hits[0] = count_nxt > {1'b0, cfg.step_limit};

  ssc_chan_test u_load (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .cur        (in_load_r),
    .low_limit  (cfg.load_low_limit),
    .high_limit (cfg.load_high_limit),
    .gate       (gate),
    .hits       (hits[LOAD_BASE +: CHAN_TESTS])
  );

  ssc_chan_test u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .cur        (in_state_r),
    .low_limit  (cfg.state_low_limit),
    .high_limit (cfg.state_high_limit),
    .gate       (gate),
    .hits       (hits[STATE_BASE +: CHAN_TESTS])
  );

  // Criterion zero is always active; pick the lowest firing index
  assign enabled = {cfg.enable_mask[NUM_CRIT-1:1], 1'b1};
  assign fired   = hits & enabled;

  always_comb begin
    crit = CRIT_NONE;
    for (int i = NUM_CRIT - 1; i >= 0; i--) begin
      if (fired[i]) begin
        crit = CRIT_W'(i);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stop_r <= |fired;
      out_crit_r <= crit;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_crit_r, out_stop_r});

endmodule

// ===== sv/ssc_cfg_regs.sv =====
// Configuration register file with APB-style write and read access.
module ssc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ssc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  output ssc_pkg::cfg_t                      cfg
);
  import ssc_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg        = cfg_r;

  // Decode the write; unknown indexes leave everything as it is
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE_MASK:      cfg_nxt.enable_mask      = cfg_pwdata[NUM_CRIT-1:0];
        REG_STEP_LIMIT:       cfg_nxt.step_limit       = cfg_pwdata[COUNT_WIDTH-1:0];
        REG_LOAD_LOW_LIMIT:   cfg_nxt.load_low_limit   = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_LOAD_HIGH_LIMIT:  cfg_nxt.load_high_limit  = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_STATE_LOW_LIMIT:  cfg_nxt.state_low_limit  = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_STATE_HIGH_LIMIT: cfg_nxt.state_high_limit = cfg_pwdata[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask      <= NUM_CRIT'(1);
      cfg_r.step_limit       <= {COUNT_WIDTH{1'b1}};
      cfg_r.load_low_limit   <= VALUE_MOST_NEG;
      cfg_r.load_high_limit  <= VALUE_MOST_POS;
      cfg_r.state_low_limit  <= VALUE_MOST_NEG;
      cfg_r.state_high_limit <= VALUE_MOST_POS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE_MASK:      cfg_prdata = CFG_DATA_W'(cfg_r.enable_mask);
      REG_STEP_LIMIT:       cfg_prdata = CFG_DATA_W'(cfg_r.step_limit);
      REG_LOAD_LOW_LIMIT:   cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.load_low_limit));
      REG_LOAD_HIGH_LIMIT:  cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.load_high_limit));
      REG_STATE_LOW_LIMIT:  cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.state_low_limit));
      REG_STATE_HIGH_LIMIT: cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.state_high_limit));
      default:              cfg_prdata = '0;
    endcase
  end

endmodule

// ===== sv/ssc_chan_test.sv =====
// Two-deep history and the six stop tests of one value channel.
module ssc_chan_test (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  advance,
  input  logic signed [ssc_pkg::VALUE_WIDTH-1:0] cur,
  input  logic signed [ssc_pkg::VALUE_WIDTH-1:0] low_limit,
  input  logic signed [ssc_pkg::VALUE_WIDTH-1:0] high_limit,
  input  ssc_pkg::cnt_gate_t                    gate,
  output logic [ssc_pkg::CHAN_TESTS-1:0]        hits
);
  import ssc_pkg::*;

  logic signed [VALUE_WIDTH-1:0] p1_r;
  logic signed [VALUE_WIDTH-1:0] p2_r;
  logic                          cur_neg;
  logic                          cur_pos;
  logic                          p1_neg;
  logic                          p1_pos;

  assign cur_neg = cur[VALUE_WIDTH-1];
  assign cur_pos = !cur[VALUE_WIDTH-1] && (cur != '0);
  assign p1_neg  = p1_r[VALUE_WIDTH-1];
  assign p1_pos  = !p1_r[VALUE_WIDTH-1] && (p1_r != '0);

  // Limits, local extremes and sign changes, lowest bit first
  assign hits[0] = cur < low_limit;
  assign hits[1] = cur > high_limit;
  assign hits[2] = gate.ge3 && (p1_r < p2_r) && (p1_r < cur);
  assign hits[3] = gate.ge3 && (p1_r > p2_r) && (p1_r > cur);
  assign hits[4] = gate.ge2 && cur_neg && p1_pos;
  assign hits[5] = gate.ge2 && cur_pos && p1_neg;

  // Shift the history once the item has been tested
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
    end else if (advance) begin
      p2_r <= p1_r;
      p1_r <= cur;
    end
  end

endmodule
